// ===== sv/u2u_pkg.sv =====
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u2u_pkg;

  localparam int          MaxUnits  = 4;
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [5:0]  HI_SURR   = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR   = 6'b110111;  // 0xDC00 >> 10
  localparam logic [20:0] MIN_2B    = 21'h000080;
  localparam logic [20:0] MIN_3B    = 21'h000800;
  localparam logic [20:0] MIN_4B    = 21'h010000;
  localparam logic [20:0] MAX_CP    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;

  // Units produced by one input byte, handed from the decoder to the output buffer.
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] unit;
    logic [MaxUnits-1:0]       rep;
    logic [2:0]                cnt;
    logic                      last;
  } u2u_list_t;

endpackage

// ===== sv/u2u_dec.sv =====
// Byte decoder: sequence state and the list of code units for one byte.
`timescale 1ns / 1ps

module u2u_dec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output u2u_pkg::u2u_list_t lst
);
  import u2u_pkg::*;

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        rep;
    logic        open;
    logic [1:0]  need;
    logic [20:0] bits;
  } fresh_t;

  logic [1:0]  need_r, need_nxt;
  logic [1:0]  have_r, have_nxt;
  logic [20:0] acc_r, acc_nxt;

  fresh_t      fr;
  logic [2:0]  n;
  logic [1:0]  have_inc;
  logic [20:0] acc_ext;
  logic [19:0] v;
  logic        bad;
  logic        take_fresh;

  // Decode a byte as if no sequence were open.
  function automatic fresh_t fresh_f(input logic [7:0] b, input logic last);
    fresh_t f;
    f = '0;
    if (b[7] == 1'b0) begin
      f.emit = 1'b1;
      f.unit = {8'h00, b};
    end else begin
      if (b[7:5] == 3'b110) begin
        f.need = 2'd1;
        f.bits = {16'h0000, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        f.need = 2'd2;
        f.bits = {17'h00000, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        f.need = 2'd3;
        f.bits = {18'h00000, b[2:0]};
      end
      // stray continuation, invalid lead, or a lead cut by the string end
      if (f.need == 2'd0 || last) begin
        f.emit = 1'b1;
        f.unit = REPL_UNIT;
        f.rep  = 1'b1;
        f.need = 2'd0;
      end else begin
        f.open = 1'b1;
      end
    end
    return f;
  endfunction

  always_comb begin
    lst        = '0;
    lst.last   = in_last;
    n          = 3'd0;
    need_nxt   = need_r;
    have_nxt   = have_r;
    acc_nxt    = acc_r;
    fr         = fresh_f(in_byte, in_last);
    take_fresh = 1'b0;
    have_inc   = have_r + 2'd1;
    acc_ext    = {acc_r[14:0], in_byte[5:0]};
    v          = 20'(acc_ext - MIN_4B);
    bad        = 1'b0;

    case (need_r)
      2'd1:    bad = acc_ext < MIN_2B;
      2'd2:    bad = acc_ext < MIN_3B || (acc_ext >= SURR_LO && acc_ext <= SURR_HI);
      default: bad = acc_ext < MIN_4B || acc_ext > MAX_CP;
    endcase

    if (need_r != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        if (have_inc >= need_r) begin
          need_nxt = 2'd0;
          have_nxt = 2'd0;
          acc_nxt  = '0;
          if (bad) begin
            lst.unit[0] = REPL_UNIT;
            lst.rep[0]  = 1'b1;
            n           = 3'd1;
          end else if (acc_ext > 21'h00FFFF) begin
            lst.unit[0] = {HI_SURR, v[19:10]};
            lst.unit[1] = {LO_SURR, v[9:0]};
            n           = 3'd2;
          end else begin
            lst.unit[0] = acc_ext[15:0];
            n           = 3'd1;
          end
        end else if (in_last) begin
          // lead plus every continuation held, including this one
          for (int i = 0; i < MaxUnits; i++) begin
            if (3'(i) <= {1'b0, have_inc}) begin
              lst.unit[i] = REPL_UNIT;
              lst.rep[i]  = 1'b1;
            end
          end
          n        = {1'b0, have_inc} + 3'd1;
          need_nxt = 2'd0;
          have_nxt = 2'd0;
          acc_nxt  = '0;
        end else begin
          have_nxt = have_inc;
          acc_nxt  = acc_ext;
        end
      end else begin
        // broken sequence: flush, then treat the byte as fresh
        for (int i = 0; i < MaxUnits; i++) begin
          if (3'(i) <= {1'b0, have_r}) begin
            lst.unit[i] = REPL_UNIT;
            lst.rep[i]  = 1'b1;
          end
        end
        n          = {1'b0, have_r} + 3'd1;
        need_nxt   = 2'd0;
        have_nxt   = 2'd0;
        acc_nxt    = '0;
        take_fresh = 1'b1;
      end
    end else begin
      take_fresh = 1'b1;
    end

    if (take_fresh) begin
      if (fr.emit) begin
        lst.unit[n[1:0]] = fr.unit;
        lst.rep[n[1:0]]  = fr.rep;
        n                = n + 3'd1;
      end
      if (fr.open) begin
        need_nxt = fr.need;
        have_nxt = 2'd0;
        acc_nxt  = fr.bits;
      end
    end
    lst.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      have_r <= 2'd0;
      acc_r  <= '0;
    end else if (load) begin
      need_r <= need_nxt;
      have_r <= have_nxt;
      acc_r  <= acc_nxt;
    end
  end

  a_have_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r == 2'd0 && have_r == 2'd0) || (have_r < need_r))
    else $error("held continuation count not below sequence length");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_last) |=> (need_r == 2'd0))
    else $error("sequence left open after the final byte");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_last) |-> (lst.cnt != 3'd0))
    else $error("final byte produced no unit");

endmodule

// ===== sv/u2u_obuf.sv =====
// Output buffer: holds a byte's units, sends one per cycle unless out_tready is low.
`timescale 1ns / 1ps

module u2u_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u2u_pkg::u2u_list_t lst,
  output logic               free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // [15:0] code_unit, [16] replaced, zero fill
  output logic               out_tlast,  // run_last
  output logic               out_tuser   // string_end
);
  import u2u_pkg::*;

  u2u_list_t  lst_r;
  logic [2:0] rem_r;
  logic [1:0] idx_r;

  assign out_tvalid = rem_r != 3'd0;
  // buffer can take a new list when empty or once its final unit leaves this cycle
  assign free       = (rem_r == 3'd0) || (rem_r == 3'd1 && out_tready);
  assign out_tdata  = {7'b0, lst_r.rep[idx_r], lst_r.unit[idx_r]};
  assign out_tlast  = rem_r == 3'd1;
  assign out_tuser  = (rem_r == 3'd1) && lst_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      rem_r <= lst.cnt;
      idx_r <= 2'd0;
    end else if (out_tvalid && out_tready) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lst_r <= lst;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, idx_r} + {1'b0, rem_r}) <= 4'(MaxUnits))
    else $error("read index ran past the stored units");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("list loaded over pending units");

endmodule

// ===== sv/utf8_to_utf16_transcoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   channel  dir  tdata                          tlast       tuser
//   in_      in   [7:0] in_byte                  in_last     -
//   out_     out  [15:0] code_unit, [16] replaced run_last   string_end
//
// One byte per cycle when each byte yields at most one unit and out_tready is
// high; a byte that yields more units holds the input while the output buffer
// drains them. Path: input register, then decode into the output buffer.
// A stall on out_tready backs up through the buffer and the input register.
// Reset is synchronous, active low, and closes any open sequence.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] code_unit, [16] replaced, zero fill
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // string_end
);
  import u2u_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       free;
  logic       load;
  u2u_list_t  lst;

  assign load      = in_vld_r && free;
  assign in_tready = !in_vld_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  u2u_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .lst     (lst)
  );

  u2u_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .lst        (lst),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/utf16_unit_checker.sv =====
// Checker for the UTF-8 to UTF-16 transcoder: predicts code units per request and compares.
`timescale 1ns / 1ps

module utf16_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          units_pending,
  output int          units_checked,
  output int          repl_checked
);
  import u2u_pkg::*;

  typedef struct packed {
    logic [15:0] code;
    logic        rep;
    logic        run_end;
    logic        str_end;
  } utf16_unit_t;

  utf16_unit_t unit_q[$];
  utf16_unit_t staged [MaxUnits];
  int          staged_n;
  utf16_unit_t got;
  utf16_unit_t want;

  // decoder state: continuation bytes needed / held, gathered code point bits
  logic [1:0]  seq_need;
  logic [1:0]  seq_have;
  logic [20:0] seq_bits;

  initial begin
    fail_count    = 0;
    units_pending = 0;
    units_checked = 0;
    repl_checked  = 0;
    seq_need      = '0;
    seq_have      = '0;
    seq_bits      = '0;
  end

  task automatic stage_unit(input logic [15:0] code, input logic rep);
    if (staged_n < MaxUnits) begin
      staged[staged_n].code    = code;
      staged[staged_n].rep     = rep;
      staged[staged_n].run_end = 1'b0;
      staged[staged_n].str_end = 1'b0;
      staged_n++;
    end
  endtask

  // one replacement for the lead plus one per held continuation byte
  task automatic flush_open_seq;
    stage_unit(REPL_UNIT, 1'b1);
    for (int i = 0; i < seq_have; i++) stage_unit(REPL_UNIT, 1'b1);
    seq_need = '0;
    seq_have = '0;
    seq_bits = '0;
  endtask

  task automatic start_fresh(input logic [7:0] b, input logic fin);
    logic [1:0]  need;
    logic [20:0] bits;
    need = '0;
    bits = '0;
    casez (b)
      8'b110?????: begin
        need = 2'd1;
        bits = {16'd0, b[4:0]};
      end
      8'b1110????: begin
        need = 2'd2;
        bits = {17'd0, b[3:0]};
      end
      8'b11110???: begin
        need = 2'd3;
        bits = {18'd0, b[2:0]};
      end
      default: ;
    endcase
    if (b[7] == 1'b0) begin
      stage_unit({8'h00, b}, 1'b0);
    end else if (need == 2'd0 || fin) begin
      // stray continuation, invalid lead, or a lead cut by the end of string
      stage_unit(REPL_UNIT, 1'b1);
    end else begin
      seq_need = need;
      seq_have = '0;
      seq_bits = bits;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [20:0] cp;
    logic [20:0] off;
    logic        bad;
    staged_n = 0;
    if (seq_need != 2'd0 && b[7:6] == 2'b10) begin
      seq_bits = {seq_bits[14:0], b[5:0]};
      seq_have = seq_have + 2'd1;
      if (seq_have >= seq_need) begin
        cp = seq_bits;
        case (seq_need)
          2'd1:    bad = cp < MIN_2B;
          2'd2:    bad = cp < MIN_3B || (cp >= SURR_LO && cp <= SURR_HI);
          default: bad = cp < MIN_4B || cp > MAX_CP;
        endcase
        if (bad) begin
          stage_unit(REPL_UNIT, 1'b1);
        end else if (cp > 21'h00FFFF) begin
          off = cp - MIN_4B;
          stage_unit({HI_SURR, off[19:10]}, 1'b0);
          stage_unit({LO_SURR, off[9:0]}, 1'b0);
        end else begin
          stage_unit(cp[15:0], 1'b0);
        end
        seq_need = '0;
        seq_have = '0;
        seq_bits = '0;
      end else if (fin) begin
        flush_open_seq();
      end
    end else begin
      if (seq_need != 2'd0) flush_open_seq();
      start_fresh(b, fin);
    end
    if (staged_n > 0) begin
      staged[staged_n-1].run_end = 1'b1;
      staged[staged_n-1].str_end = fin;
    end
    for (int i = 0; i < staged_n; i++) unit_q.push_back(staged[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      unit_q.delete();
      seq_need = '0;
      seq_have = '0;
      seq_bits = '0;
    end else begin
      // a request accepted at this edge cannot surface at the same edge
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.code    = out_tdata[15:0];
        got.rep     = out_tdata[16];
        got.run_end = out_tlast;
        got.str_end = out_tuser;
        if (unit_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected unit %h rep %b run %b end %b", $realtime,
                     got.code, got.rep, got.run_end, got.str_end);
          fail_count++;
        end else begin
          want = unit_q.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("%0t: unit %0d exp %h rep %b run %b end %b, got %h rep %b run %b end %b",
                       $realtime, units_checked, want.code, want.rep, want.run_end,
                       want.str_end, got.code, got.rep, got.run_end, got.str_end);
            fail_count++;
          end
          if (want.rep) repl_checked++;
          units_checked++;
        end
      end
    end
    units_pending <= unit_q.size();
  end

endmodule

// ===== tb/utf8_to_utf16_transcoder_unit_tb.sv =====
// Testbench top: drives UTF-8 strings into the transcoder and gives the verdict.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_unit_tb;
  import u2u_pkg::*;

  localparam int RandomBytes = 154;
  localparam int LongHold    = 300;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int fail_count;
  int units_pending;
  int units_checked;
  int repl_checked;

  int          bytes_sent    = 0;
  int          strings_sent  = 0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  logic [31:0] rx_cycle      = '0;
  rx_mode_e    rx_mode       = RX_OPEN;

  logic [7:0]  str_bytes[$];

  // bit 8 marks the last byte of a string
  logic [8:0] directed_bytes [0:25] = '{
    9'h000, 9'h17F,                  // ASCII extremes
    9'h0EF, 9'h0BF, 9'h0BD,          // properly encoded U+FFFD
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // U+10FFFF as a surrogate pair
    9'h0C0, 9'h080,                  // overlong two-byte
    9'h0ED, 9'h0A0, 9'h080,          // encoded surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080,  // above U+10FFFF
    9'h080, 9'h0FF,                  // stray continuation, invalid lead
    9'h0E2, 9'h141,                  // lead broken by ASCII
    9'h0F0, 9'h090, 9'h080, 9'h1C3   // two held bytes broken by a lead at end of string
  };

  utf8_to_utf16_transcoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  utf16_unit_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .units_pending(units_pending),
    .units_checked(units_checked),
    .repl_checked (repl_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: randomly chosen ready patterns in turn; long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_tready <= 1'b0;
      hold_left  <= LongHold;
      holds_done <= holds_done + 1;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    bytes_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    repeat (3) @(posedge clk);
    while (units_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_encoded(input logic [20:0] cp, input int len);
    case (len)
      1: str_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // mostly well-formed characters, the rest malformed or random bytes
  task automatic add_random_char;
    int pick;
    int len;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_encoded(21'($urandom_range(0, 127)), 1);
    end else if (pick < 35) begin
      add_encoded(21'($urandom_range(32'h80, 32'h7FF)), 2);
    end else if (pick < 50) begin
      add_encoded(21'($urandom_range(32'h800, 32'hFFFF)), 3);
    end else if (pick < 65) begin
      add_encoded(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    end else if (pick < 70) begin
      // overlong: value fits a shorter form
      len = $urandom_range(2, 4);
      add_encoded(21'($urandom_range(0, (len == 2) ? 32'h7F : (len == 3) ? 32'h7FF : 32'hFFFF)),
                  len);
    end else if (pick < 74) begin
      add_encoded(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
    end else if (pick < 78) begin
      add_encoded(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
    end else if (pick < 82) begin
      str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 85) begin
      str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (pick < 95) begin
      // truncated sequence: lead kept, tail dropped
      len = $urandom_range(2, 4);
      add_encoded(21'($urandom_range(0, 32'h1FFFFF)), len);
      cut = $urandom_range(1, len - 1);
      repeat (cut) void'(str_bytes.pop_back());
    end else begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_string;
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
    strings_sent++;
  endtask

  initial begin
    int str_idx;
    int n_chars;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 26; i++) begin
      send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
      if (directed_bytes[i][8]) strings_sent++;
    end
    drain_results();

    str_idx = 0;
    while (bytes_sent < 26 + RandomBytes) begin
      if (str_idx == 6 || str_idx == 40) hold_requests <= hold_requests + 1;
      if (str_idx == 25) drain_results();
      n_chars = $urandom_range(1, 6);
      repeat (n_chars) add_random_char();
      send_string();
      str_idx++;
    end
    drain_results();
    repeat (10) @(posedge clk);

    if (units_pending != 0)
      $display("%0d expected code units never arrived", units_pending);
    $display("Sent %0d bytes in %0d strings; checked %0d code units, %0d of them replacements.",
             bytes_sent, strings_sent, units_checked, repl_checked);
    $display("Covered pairs, overlong, surrogate, out-of-range, broken and cut sequences.");
    if (fail_count == 0 && units_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Run timed out");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
